/* design/ars_pkg.sv */
package ars_pkg;

  // Data widths
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned IMG_W   = 16;
  localparam int unsigned ROB_W   = 32;
  localparam int unsigned ERR_W   = 32;
  localparam int unsigned SUM_W   = 42;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned CFG_IDX_W = 3;

  // Saturation bound of the pair counter
  localparam logic [CNT_W-1:0] MAX_POINTS = CNT_W'(1024);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_E = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_F = 3'd5;

  // Reset values of the transform (identity)
  localparam logic [COEF_W-1:0] COEF_UNITY = 32'h0001_0000;

  typedef struct packed {
    logic [IMG_W-1:0]        image_u;
    logic [IMG_W-1:0]        image_v;
    logic signed [ROB_W-1:0] robot_x;
    logic signed [ROB_W-1:0] robot_y;
    logic                    pair_complete;
    logic                    last_pair;
  } ars_in_t;

  typedef struct packed {
    logic [ERR_W-1:0] point_error;
    logic             error_valid;
    logic             set_done;
    logic [ERR_W-1:0] mean_error;
    logic [ERR_W-1:0] max_error;
    logic [CNT_W-1:0] point_count;
    logic             no_points;
  } ars_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_AU,
    S_MUL_BV,
    S_DX,
    S_MUL_EV,
    S_DY,
    S_SQX,
    S_SQY,
    S_SQRT,
    S_STAT,
    S_DIV,
    S_OUT
  } ars_state_e;

endpackage

/* design/affine_residual_error_stats.sv */
// Affine residual error statistics. Pulse start with a calibration pair on
// in_i while busy is low; busy rises on the next cycle and stays high until
// the single result transaction has been shown. The result appears on
// result_o for exactly one cycle with done_o high, and the receiver cannot
// stall it, so capture it on that edge. A complete pair that is not the last
// of its set runs from start to done_o through the shared 33x33 multiplier
// (two gain products per axis, then the two squares), an add of the squares,
// the digit-by-digit square root, the statistics update and the result
// state. A complete pair whose residual saturates skips the square root. An
// incomplete pair skips straight to the statistics update. The last pair of
// a set with at least one counted point adds a restoring division for the
// mean, on the same subtract unit as the square root. Coefficient writes on
// the cfg channel are always taken (cfg_ready_o is tied high) and must only be
// made while busy is low; an index beyond coef_f is dropped.
module affine_residual_error_stats (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  ars_pkg::ars_in_t           in_i,
  output logic                       done_o,
  output ars_pkg::ars_out_t          result_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ars_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ars_pkg::COEF_W-1:0] cfg_data_i
);
  import ars_pkg::*;

  // Coefficient registers
  logic [COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q, coef_e_q, coef_f_q;

  // Sequencer
  ars_state_e state_q, state_d;
  logic [5:0] step_q;

  // Captured transaction and datapath registers
  ars_in_t           item_q;
  logic signed [65:0] prod_q;
  logic signed [49:0] acc_q;
  logic signed [44:0] dx_q, dy_q;
  logic              ovf_q;
  logic [63:0]       sq_q;
  logic [63:0]       work_q;
  logic [34:0]       rem_q;
  logic [41:0]       root_q;
  logic [ERR_W-1:0]  err_q;
  ars_out_t          res_q;

  // Statistics
  logic [SUM_W-1:0]  sum_q;
  logic [ERR_W-1:0]  peak_q;
  logic [CNT_W-1:0]  count_q;

  logic accept;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= COEF_UNITY;
      coef_b_q <= '0;
      coef_c_q <= '0;
      coef_d_q <= '0;
      coef_e_q <= COEF_UNITY;
      coef_f_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_COEF_A: coef_a_q <= cfg_data_i;
        REG_COEF_B: coef_b_q <= cfg_data_i;
        REG_COEF_C: coef_c_q <= cfg_data_i;
        REG_COEF_D: coef_d_q <= cfg_data_i;
        REG_COEF_E: coef_e_q <= cfg_data_i;
        REG_COEF_F: coef_f_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: gain products first, then the two squares
  // ---------------------------------------------------------------------------
  logic [44:0]        mag_x, mag_y;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  assign mag_x = dx_q[44] ? 45'(-dx_q) : 45'(dx_q);
  assign mag_y = dy_q[44] ? 45'(-dy_q) : 45'(dy_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL_AU: begin
        mul_a = {coef_a_q[COEF_W-1], coef_a_q};
        mul_b = {17'd0, item_q.image_u};
      end
      S_MUL_BV: begin
        mul_a = {coef_b_q[COEF_W-1], coef_b_q};
        mul_b = {17'd0, item_q.image_v};
      end
      S_DX: begin
        mul_a = {coef_d_q[COEF_W-1], coef_d_q};
        mul_b = {17'd0, item_q.image_u};
      end
      S_MUL_EV: begin
        mul_a = {coef_e_q[COEF_W-1], coef_e_q};
        mul_b = {17'd0, item_q.image_v};
      end
      S_DY: begin
        mul_a = {1'b0, mag_x[31:0]};
        mul_b = {1'b0, mag_x[31:0]};
      end
      S_SQX: begin
        mul_a = {1'b0, mag_y[31:0]};
        mul_b = {1'b0, mag_y[31:0]};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // Affine tail: round the gain sum to Q.12, add the offset, subtract from
  // the measured point. The x or y operands follow the state.
  // ---------------------------------------------------------------------------
  logic signed [50:0] gsum;
  logic signed [44:0] offs, robot, delta;

  assign offs  = (state_q == S_DX) ? 45'(signed'(coef_c_q)) : 45'(signed'(coef_f_q));
  assign robot = (state_q == S_DX) ? 45'(signed'(item_q.robot_x)) :
                                     45'(signed'(item_q.robot_y));
  assign gsum  = 51'(acc_q) + 51'(signed'(prod_q[49:0])) + 51'sd64;
  assign delta = robot - (45'(signed'(gsum[50:7])) + offs);

  // Sum of squares; bit 64 marks wrap beyond 64 bits
  logic [64:0] sqsum;
  logic        sat;
  assign sqsum = {1'b0, sq_q} + {1'b0, prod_q[63:0]};
  assign sat   = ovf_q || sqsum[64];

  // ---------------------------------------------------------------------------
  // Shared compare/subtract unit: square-root digit step or division step
  // ---------------------------------------------------------------------------
  logic [34:0] sub_a, sub_b;
  logic [35:0] diff;
  logic        ge;
  logic [34:0] rem_d;
  logic [41:0] root_d;

  always_comb begin
    if (state_q == S_SQRT) begin
      sub_a = {rem_q[32:0], work_q[63:62]};
      sub_b = {root_q[32:0], 2'b01};
    end else begin
      sub_a = {rem_q[33:0], work_q[63]};
      sub_b = {24'd0, count_q};
    end
  end

  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge     = !diff[35];
  assign rem_d  = ge ? diff[34:0] : sub_a;
  assign root_d = {root_q[40:0], ge};

  // ---------------------------------------------------------------------------
  // Statistics update for the current pair
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_n;
  logic [ERR_W-1:0] peak_n;
  logic [CNT_W-1:0] count_n;

  always_comb begin
    sum_n   = sum_q;
    peak_n  = peak_q;
    count_n = count_q;
    if (item_q.pair_complete) begin
      if (err_q > peak_q) begin
        peak_n = err_q;
      end
      if (count_q < MAX_POINTS) begin
        sum_n   = sum_q + SUM_W'(err_q);
        count_n = count_q + CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = in_i.pair_complete ? S_MUL_AU : S_STAT;
        end
      end
      S_MUL_AU: state_d = S_MUL_BV;
      S_MUL_BV: state_d = S_DX;
      S_DX:     state_d = S_MUL_EV;
      S_MUL_EV: state_d = S_DY;
      S_DY:     state_d = S_SQX;
      S_SQX:    state_d = S_SQY;
      S_SQY:    state_d = sat ? S_STAT : S_SQRT;
      S_SQRT: begin
        if (step_q == '0) begin
          state_d = S_STAT;
        end
      end
      S_STAT: begin
        if (item_q.last_pair && count_n != '0) begin
          state_d = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (step_q == '0) begin
          state_d = S_OUT;
        end
      end
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    busy     = (state_q != S_IDLE);
    done_o   = (state_q == S_OUT);
    result_o = res_q;
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      sum_q   <= '0;
      peak_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_SQY: step_q <= 6'd31;
        S_STAT: begin
          step_q  <= 6'd41;
          sum_q   <= sum_n;
          peak_q  <= peak_n;
          count_q <= count_n;
        end
        S_SQRT, S_DIV: step_q <= step_q - 6'd1;
        S_OUT: begin
          // drop the set statistics once the last pair is reported
          if (res_q.set_done) begin
            sum_q   <= '0;
            peak_q  <= '0;
            count_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_q <= in_i;
          err_q  <= '0;
          ovf_q  <= 1'b0;
        end
      end
      S_MUL_AU: prod_q <= mul_p;
      S_MUL_BV: begin
        acc_q  <= prod_q[49:0];
        prod_q <= mul_p;
      end
      S_DX: begin
        dx_q   <= delta;
        prod_q <= mul_p;
      end
      S_MUL_EV: begin
        acc_q  <= prod_q[49:0];
        prod_q <= mul_p;
      end
      S_DY: begin
        dy_q   <= delta;
        ovf_q  <= |mag_x[44:32];
        prod_q <= mul_p;
      end
      S_SQX: begin
        sq_q   <= prod_q[63:0];
        ovf_q  <= ovf_q || (|mag_y[44:32]);
        prod_q <= mul_p;
      end
      S_SQY: begin
        if (sat) begin
          err_q <= '1;
        end
        work_q <= sqsum[63:0];
        rem_q  <= '0;
        root_q <= '0;
      end
      S_SQRT: begin
        rem_q  <= rem_d;
        root_q <= root_d;
        work_q <= {work_q[61:0], 2'b00};
        if (step_q == '0) begin
          err_q <= root_d[ERR_W-1:0];
        end
      end
      S_STAT: begin
        res_q.point_error <= err_q;
        res_q.error_valid <= item_q.pair_complete;
        res_q.set_done    <= item_q.last_pair;
        res_q.mean_error  <= '0;
        res_q.max_error   <= '0;
        res_q.point_count <= '0;
        res_q.no_points   <= item_q.last_pair && (count_n == '0);
        if (item_q.last_pair && count_n != '0) begin
          res_q.max_error   <= peak_n;
          res_q.point_count <= count_n;
        end
        // dividend enters at the top and shifts out one bit per step
        work_q <= {sum_n, 22'd0};
        rem_q  <= '0;
        root_q <= '0;
      end
      S_DIV: begin
        rem_q  <= rem_d;
        root_q <= root_d;
        work_q <= {work_q[62:0], 1'b0};
        if (step_q == '0) begin
          res_q.mean_error <= root_d[ERR_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy ##1 !busy)
    else $error("result strobe outside a transaction or not a single cycle");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.error_valid) |-> (result_o.point_error == '0))
    else $error("incomplete pair reported a nonzero error");

  a_empty_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.no_points) |->
      (result_o.set_done && result_o.point_count == '0 && result_o.mean_error == '0))
    else $error("empty set reported statistics");

  a_mean_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.set_done && !result_o.no_points) |->
      (result_o.mean_error <= result_o.max_error))
    else $error("mean above peak");

endmodule

/* tb/tb_affine_residual_error_stats.sv */
module tb_affine_residual_error_stats;
  timeunit 1ns;
  timeprecision 1ps;

  import ars_pkg::*;

  // Run limits: the slowest legal item (last pair with a divide) plus the
  // longest idle gap, over every item, taken several times over.
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 100;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 75;

  // Rounding of the Q.19 gain sum down to Q.12: add half an LSB, drop 7 bits.
  localparam longint      ROUND_HALF = 64;
  localparam int unsigned FRAC_DROP  = 7;

  // Indexes past coef_f; writes there must leave every coefficient alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_COEF_F + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  ars_in_t              in_i        = '0;
  logic                 done_o;
  ars_out_t             result_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COEF_W-1:0]    cfg_data_i  = '0;

  // Shadow copy of the transform and the running set statistics.
  logic signed [COEF_W-1:0] coef_q [0:5];
  logic [SUM_W-1:0]         acc_sum;
  logic [ERR_W-1:0]         acc_peak;
  logic [CNT_W-1:0]         acc_count;

  ars_out_t    pending_results [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  bit          no_gaps      = 1'b0;

  always #4 clk_i = ~clk_i;

  affine_residual_error_stats dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Floor square root, one root bit per step from the top.
  function automatic logic [ERR_W-1:0] floor_sqrt(logic [63:0] n);
    logic [ERR_W-1:0] root;
    logic [ERR_W-1:0] trial;
    root = '0;
    for (int i = ERR_W - 1; i >= 0; i--) begin
      trial = root | (ERR_W'(1) << i);
      if (64'(trial) * 64'(trial) <= n) root = trial;
    end
    return root;
  endfunction

  // Distance from the measured robot point to the mapped image point, Q20.12.
  function automatic logic [ERR_W-1:0] predict_residual(ars_in_t p);
    longint      sum_x, sum_y, px, py, dx, dy;
    logic [63:0] ax, ay;
    logic [64:0] sq_sum;
    sum_x = longint'(coef_q[REG_COEF_A]) * longint'(p.image_u)
          + longint'(coef_q[REG_COEF_B]) * longint'(p.image_v);
    sum_y = longint'(coef_q[REG_COEF_D]) * longint'(p.image_u)
          + longint'(coef_q[REG_COEF_E]) * longint'(p.image_v);
    // Arithmetic shift floors, so this is round half up.
    px = ((sum_x + ROUND_HALF) >>> FRAC_DROP) + longint'(coef_q[REG_COEF_C]);
    py = ((sum_y + ROUND_HALF) >>> FRAC_DROP) + longint'(coef_q[REG_COEF_F]);
    dx = longint'($signed(p.robot_x)) - px;
    dy = longint'($signed(p.robot_y)) - py;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    // Saturate when either leg leaves 32 bits or the sum of squares leaves 64 bits.
    if (ax > 64'hFFFF_FFFF || ay > 64'hFFFF_FFFF) return '1;
    sq_sum = 65'(ax * ax) + 65'(ay * ay);
    if (sq_sum[64]) return '1;
    return floor_sqrt(sq_sum[63:0]);
  endfunction

  // Fold one accepted pair into the set statistics and build its result.
  function automatic ars_out_t fold_pair(ars_in_t p);
    ars_out_t         r;
    logic [ERR_W-1:0] err;
    r   = '0;
    err = '0;
    if (p.pair_complete) begin
      err = predict_residual(p);
      if (err > acc_peak) acc_peak = err;
      // Past the count bound the peak still moves, the mean does not.
      if (acc_count < MAX_POINTS) begin
        acc_sum   = acc_sum + err;
        acc_count = acc_count + 1'b1;
      end
    end
    r.point_error = err;
    r.error_valid = p.pair_complete;
    r.set_done    = p.last_pair;
    if (p.last_pair) begin
      if (acc_count == '0) begin
        r.no_points = 1'b1;
      end else begin
        r.mean_error  = ERR_W'(acc_sum / acc_count);
        r.max_error   = acc_peak;
        r.point_count = acc_count;
      end
      acc_sum   = '0;
      acc_peak  = '0;
      acc_count = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: the receiver cannot stall, so sample every done_o cycle.
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    ars_out_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result transaction with none outstanding, expected none, got %p",
                 $time, result_o);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        compare_field("point_error", want.point_error, result_o.point_error);
        compare_field("error_valid", want.error_valid, result_o.error_valid);
        compare_field("set_done",    want.set_done,    result_o.set_done);
        compare_field("mean_error",  want.mean_error,  result_o.mean_error);
        compare_field("max_error",   want.max_error,   result_o.max_error);
        compare_field("point_count", want.point_count, result_o.point_count);
        compare_field("no_points",   want.no_points,   result_o.no_points);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one pair after an optional idle gap and hold it until the block
  // takes it. Leave start high on return so back-to-back items never drop it.
  task automatic send_pair(input ars_in_t p, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= p;
    do @(posedge clk_i); while (busy);
    pending_results.insert(pending_results.size(), fold_pair(p));
  endtask

  // Drop start and hold until every expected result is in and the block idles.
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One configuration transaction; valid is dropped again before the task returns.
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= REG_COEF_F) coef_q[idx] = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b,
                            input logic [COEF_W-1:0] c, input logic [COEF_W-1:0] d,
                            input logic [COEF_W-1:0] e, input logic [COEF_W-1:0] f);
    wait_quiet();
    write_coef(REG_COEF_A, a);
    write_coef(REG_COEF_B, b);
    write_coef(REG_COEF_C, c);
    write_coef(REG_COEF_D, d);
    write_coef(REG_COEF_E, e);
    write_coef(REG_COEF_F, f);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic ars_in_t make_pair(logic [IMG_W-1:0] u, logic [IMG_W-1:0] v,
                                        logic [ROB_W-1:0] rx, logic [ROB_W-1:0] ry,
                                        logic complete, logic last);
    ars_in_t p;
    p.image_u       = u;
    p.image_v       = v;
    p.robot_x       = rx;
    p.robot_y       = ry;
    p.pair_complete = complete;
    p.last_pair     = last;
    return p;
  endfunction

  // Two's complement value spread evenly over -span..+span.
  function automatic logic [31:0] jitter(int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly short gaps, some long enough to land deep in the square root or
  // the divide, and none at all while a burst is running.
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (no_gaps || sel < 45) return 0;
    if (sel < 85) return $urandom_range(1, 12);
    if (sel < 97) return $urandom_range(13, 60);
    return $urandom_range(61, 150);
  endfunction

  // Robot points mostly near the origin so near-identity transforms give
  // unsaturated residuals; wide pairs also draw full-range coordinates.
  function automatic ars_in_t random_pair(logic complete, logic last, bit wide);
    logic [ROB_W-1:0] rx, ry;
    if (wide && $urandom_range(0, 9) < 3) begin
      rx = $urandom;
      ry = $urandom;
    end else begin
      rx = jitter(1 << 26);
      ry = jitter(1 << 26);
    end
    return make_pair(IMG_W'($urandom), IMG_W'($urandom), rx, ry, complete, last);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset transform is identity: empty set, zero residual, extreme coordinates,
  // an incomplete pair inside a set and an exact 3-4-5 residual.
  task automatic test_identity_transform();
    send_pair(make_pair('0, '0, '0, '0, 1'b0, 1'b1), pick_gap());
    send_pair(make_pair('0, '0, '0, '0, 1'b1, 1'b1), pick_gap());
    send_pair(make_pair('1, '1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0), pick_gap());
    send_pair(make_pair('1, '1, $urandom, $urandom, 1'b0, 1'b0), pick_gap());
    // One pixel right of the origin maps to 1.0; off by (3, 4) gives 5.0.
    send_pair(make_pair(16'd8, '0, 32'd16384, 32'd16384, 1'b1, 1'b1), pick_gap());
  endtask

  // Every register at one of its extremes, writes past coef_f ignored, rounding of
  // exact half steps in both directions and both saturation paths.
  task automatic test_coefficient_registers();
    load_coefs(32'd1, '1, '0, '0, '0, '0);
    write_coef(REG_SPARE_LO, $urandom);
    write_coef(REG_SPARE_HI, $urandom);
    send_pair(make_pair(16'd64, '0, '0, '0, 1'b1, 1'b0), pick_gap());
    send_pair(make_pair('0, 16'd64, '0, '0, 1'b1, 1'b0), pick_gap());
    send_pair(make_pair('0, 16'd65, '0, '0, 1'b1, 1'b1), pick_gap());

    // Gains at full scale throw the mapped point far out of range.
    load_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pair(make_pair('1, '1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1), pick_gap());

    // Offsets alone: both legs just under 2^32 overflow the sum of squares;
    // one leg alone gives the largest and next-largest exact roots.
    load_coefs('0, '0, 32'h7FFF_FFFF, '0, '0, 32'h8000_0000);
    send_pair(make_pair($urandom, $urandom, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0),
              pick_gap());
    send_pair(make_pair($urandom, $urandom, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0),
              pick_gap());
    send_pair(make_pair($urandom, $urandom, 32'h8000_0001, 32'h8000_0000, 1'b1, 1'b1),
              pick_gap());
  endtask

  // Fill the counter to its bound, then push more complete pairs: one with a
  // far larger residual must raise the peak but leave the mean alone.
  task automatic test_count_saturation();
    load_coefs(COEF_UNITY, '0, '0, '0, COEF_UNITY, '0);
    for (int k = 0; k < int'(MAX_POINTS); k++)
      send_pair(random_pair(1'b1, 1'b0, 1'b0), $urandom_range(0, 2));
    send_pair(random_pair(1'b1, 1'b0, 1'b0), $urandom_range(0, 2));
    send_pair(make_pair('0, '0, 32'h8000_0000, '0, 1'b1, 1'b0), $urandom_range(0, 2));
    send_pair(random_pair(1'b0, 1'b0, 1'b1), $urandom_range(0, 2));
    send_pair(random_pair(1'b1, 1'b0, 1'b0), $urandom_range(0, 2));
    send_pair(random_pair(1'b0, 1'b1, 1'b1), $urandom_range(0, 2));
  endtask

  // Random sets under a rotating choice of transforms; the block is drained
  // before each reload, which also pauses the sender until all results land.
  task automatic test_random_sets();
    int unsigned sent;
    int unsigned len;
    bit          empty_set;
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: load_coefs(COEF_UNITY + jitter(4096), jitter(2048), jitter(1 << 24),
                      jitter(2048), COEF_UNITY + jitter(4096), jitter(1 << 24));
        1: load_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        2: load_coefs(-COEF_UNITY + jitter(4096), jitter(2048), jitter(1 << 24),
                      jitter(2048), -COEF_UNITY + jitter(4096), jitter(1 << 24));
        default: load_coefs(pick_extreme(), pick_extreme(), pick_extreme(),
                            pick_extreme(), pick_extreme(), pick_extreme());
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len       = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        no_gaps   = ($urandom_range(0, 3) == 0);
        empty_set = ($urandom_range(0, 19) == 0);
        for (int unsigned k = 0; k < len; k++)
          send_pair(random_pair(!empty_set && $urandom_range(0, 4) != 0,
                                k == len - 1, 1'b1), pick_gap());
        sent += len;
      end
      no_gaps = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : run_tests
    // Shadow state matches the block after reset.
    coef_q[REG_COEF_A] = COEF_UNITY;
    coef_q[REG_COEF_B] = '0;
    coef_q[REG_COEF_C] = '0;
    coef_q[REG_COEF_D] = '0;
    coef_q[REG_COEF_E] = COEF_UNITY;
    coef_q[REG_COEF_F] = '0;
    acc_sum   = '0;
    acc_peak  = '0;
    acc_count = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_identity_transform();
    test_coefficient_registers();
    test_count_saturation();
    test_random_sets();

    // Drain, then watch a while longer for stray result transactions.
    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t ns: results outstanding at end, expected 0, got %0d",
               $time, pending_results.size());
      mismatch_cnt++;
    end

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
